// ===== rtl/sfrc_pkg.sv =====
// Shared types and constants for the sum8 frame receive checker.
// Used by every module under rtl/; depends on nothing.

package sfrc_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned DacW   = 12;
  localparam int unsigned StatW  = 3;

  // Frame layout
  localparam int unsigned MaxFrameBytesDef = 511;
  localparam int unsigned MinFrameBytes    = 7;   // head, addr x2, cmd, len, data, sum
  localparam int unsigned OverheadBytes    = 6;   // bytes besides the data field

  // Set-parameter values carried in the first data byte
  localparam logic [ByteW-1:0] ParamLow      = 8'd1;
  localparam logic [ByteW-1:0] ParamHigh     = 8'd2;
  localparam logic [ByteW-1:0] ParamFeedback = 8'd3;

  // Register reset values
  localparam logic [ByteW-1:0] HeadValueRst    = 8'd170;
  localparam logic [ByteW-1:0] SetParamCodeRst = 8'd1;
  localparam logic [DacW-1:0]  DacCodeLowRst   = 12'd248;
  localparam logic [DacW-1:0]  DacCodeHighRst  = 12'd372;

  // Configuration register map, index = paddr[3:2]
  localparam int unsigned AddrW = 4;
  typedef enum logic [1:0] {
    REG_HEAD_VALUE     = 2'd0,
    REG_SET_PARAM_CODE = 2'd1,
    REG_DAC_CODE_LOW   = 2'd2,
    REG_DAC_CODE_HIGH  = 2'd3
  } reg_idx_e;

  // Frame status codes
  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_HEAD  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_SUM   = 3'd4
  } status_e;

  // Configuration as seen by the checker
  typedef struct packed {
    logic [ByteW-1:0] head_value;
    logic [ByteW-1:0] set_param_code;
    logic [DacW-1:0]  dac_code_low;
    logic [DacW-1:0]  dac_code_high;
  } cfg_t;

  // One result request
  typedef struct packed {
    logic             feedback_on;
    logic [DacW-1:0]  dac_level;
    logic             dac_write;
    logic             charge_enable;
    logic             set_param_seen;
    status_e          status;
  } result_t;

endpackage

// ===== rtl/sum8_frame_receive_checker_core.sv =====
// Top level of the sum8 frame receive checker: input register and wiring.
// Depends on sfrc_pkg, sfrc_cfg_regs and sfrc_check.

// The block takes one received byte per request on the slave stream, with
// tlast on the frame's last byte, and returns one result request on the
// master stream for every last byte: status, set-parameter flag, charge and
// DAC pulses with the DAC code, and the feedback flag. A byte passes through
// an input register and the check logic into the result register. A frame's
// result is presented from the result register once its last byte has
// passed the input register and the checks; a new byte can be taken in
// every cycle. Only a result not yet taken holds back the next frame's last
// byte, and the bytes behind it wait upstream. The byte count saturates at
// MAX_FRAME_BYTES; such a frame is a length error unless its head is wrong.
// Registers (byte address): head value 0x0, set-parameter code 0x4,
// low DAC code 0x8, high DAC code 0xC; write them only while idle.

module sum8_frame_receive_checker_core #(
  parameter int unsigned MAX_FRAME_BYTES = sfrc_pkg::MaxFrameBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input byte stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  input  logic                        s_axis_tlast,   // frame_end
  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,   // [2:0] status, [3] set_param_seen,
                                                      // [4] charge_enable, [5] dac_write,
                                                      // [17:6] dac_level, [18] feedback_on
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfrc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  sfrc_pkg::cfg_t    cfg;
  sfrc_pkg::result_t res;

  logic                       in_valid_q;
  logic [sfrc_pkg::ByteW-1:0] in_byte_q;
  logic                       in_last_q;
  logic                       in_adv;
  logic                       in_fire;

  assign s_axis_tready = ~in_valid_q | in_adv;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (in_adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  sfrc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfrc_check #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_byte_i   (in_byte_q),
    .in_last_i   (in_last_q),
    .in_adv_o    (in_adv),
    .cfg_i       (cfg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Result packing
  assign m_axis_tdata = {5'b0, res.feedback_on, res.dac_level, res.dac_write,
                         res.charge_enable, res.set_param_seen, res.status};

endmodule

// ===== rtl/sfrc_cfg_regs.sv =====
// APB-style configuration registers of the frame checker.
// Depends on sfrc_pkg for the register map, reset values and cfg_t.

module sfrc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfrc_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output sfrc_pkg::cfg_t               cfg_o
);

  sfrc_pkg::cfg_t     cfg_q;
  sfrc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = sfrc_pkg::reg_idx_e'(paddr[sfrc_pkg::AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_value     <= sfrc_pkg::HeadValueRst;
      cfg_q.set_param_code <= sfrc_pkg::SetParamCodeRst;
      cfg_q.dac_code_low   <= sfrc_pkg::DacCodeLowRst;
      cfg_q.dac_code_high  <= sfrc_pkg::DacCodeHighRst;
    end else if (wr_en) begin
      case (idx)
        sfrc_pkg::REG_HEAD_VALUE:     cfg_q.head_value     <= pwdata[sfrc_pkg::ByteW-1:0];
        sfrc_pkg::REG_SET_PARAM_CODE: cfg_q.set_param_code <= pwdata[sfrc_pkg::ByteW-1:0];
        sfrc_pkg::REG_DAC_CODE_LOW:   cfg_q.dac_code_low   <= pwdata[sfrc_pkg::DacW-1:0];
        sfrc_pkg::REG_DAC_CODE_HIGH:  cfg_q.dac_code_high  <= pwdata[sfrc_pkg::DacW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      sfrc_pkg::REG_HEAD_VALUE:     prdata = 32'(cfg_q.head_value);
      sfrc_pkg::REG_SET_PARAM_CODE: prdata = 32'(cfg_q.set_param_code);
      sfrc_pkg::REG_DAC_CODE_LOW:   prdata = 32'(cfg_q.dac_code_low);
      sfrc_pkg::REG_DAC_CODE_HIGH:  prdata = 32'(cfg_q.dac_code_high);
      default:                      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/sfrc_check.sv =====
// Frame state, end-of-frame checks and the result register.
// Depends on sfrc_pkg for widths, status codes, cfg_t and result_t.

module sfrc_check #(
  parameter int unsigned MAX_FRAME_BYTES = sfrc_pkg::MaxFrameBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [sfrc_pkg::ByteW-1:0]  in_byte_i,
  input  logic                        in_last_i,
  output logic                        in_adv_o,
  input  sfrc_pkg::cfg_t              cfg_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sfrc_pkg::result_t           out_res_o
);

  localparam int unsigned CntW = sfrc_pkg::CountW;
  localparam int unsigned BW   = sfrc_pkg::ByteW;
  localparam int unsigned LenW = CntW + 1;
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_FRAME_BYTES);
  localparam logic [CntW-1:0] MinCount = CntW'(sfrc_pkg::MinFrameBytes);
  localparam logic [LenW-1:0] Overhead = LenW'(sfrc_pkg::OverheadBytes);

  // Byte positions inside the header
  localparam logic [CntW-1:0] PosHead  = CntW'(0);
  localparam logic [CntW-1:0] PosCmd   = CntW'(3);
  localparam logic [CntW-1:0] PosLen   = CntW'(4);
  localparam logic [CntW-1:0] PosData1 = CntW'(5);

  logic [CntW-1:0] count_q, count_d;
  logic [BW-1:0]   sum_q, sum_d;
  logic [BW-1:0]   head_q, head_d;
  logic [BW-1:0]   cmd_q, cmd_d;
  logic [BW-1:0]   len_q, len_d;
  logic [BW-1:0]   data1_q, data1_d;
  logic            fb_q, fb_d;
  logic            out_valid_q, out_valid_d;
  sfrc_pkg::result_t res_q, res_d;

  logic [CntW-1:0] total;
  logic            done;

  // Frame advances unless a finished result would overwrite one still waiting
  assign in_adv_o = in_valid_i & (~in_last_i | ~out_valid_q | out_ready_i);
  assign done     = in_adv_o & in_last_i;
  assign total    = (count_q < MaxCount) ? count_q + CntW'(1) : MaxCount;

  // Header capture, checks and actions
  always_comb begin
    head_d  = (count_q == PosHead)  ? in_byte_i : head_q;
    cmd_d   = (count_q == PosCmd)   ? in_byte_i : cmd_q;
    len_d   = (count_q == PosLen)   ? in_byte_i : len_q;
    data1_d = (count_q == PosData1) ? in_byte_i : data1_q;

    if (total < MinCount) begin
      res_d.status = sfrc_pkg::ST_TOO_SHORT;
    end else if (head_d != cfg_i.head_value) begin
      res_d.status = sfrc_pkg::ST_BAD_HEAD;
    end else if (LenW'(total) != Overhead + LenW'(len_d)) begin
      res_d.status = sfrc_pkg::ST_BAD_LEN;
    end else if (in_byte_i != sum_q) begin
      res_d.status = sfrc_pkg::ST_BAD_SUM;
    end else begin
      res_d.status = sfrc_pkg::ST_OK;
    end

    res_d.set_param_seen = (res_d.status == sfrc_pkg::ST_OK) &&
                           (cmd_d == cfg_i.set_param_code);
    res_d.charge_enable  = 1'b0;
    res_d.dac_write      = 1'b0;
    res_d.dac_level      = '0;
    fb_d                 = fb_q;
    if (res_d.set_param_seen) begin
      if (data1_d == sfrc_pkg::ParamLow) begin
        res_d.charge_enable = 1'b1;
        res_d.dac_write     = 1'b1;
        res_d.dac_level     = cfg_i.dac_code_low;
      end else if (data1_d == sfrc_pkg::ParamHigh) begin
        res_d.charge_enable = 1'b1;
        res_d.dac_write     = 1'b1;
        res_d.dac_level     = cfg_i.dac_code_high;
      end else if (data1_d == sfrc_pkg::ParamFeedback) begin
        fb_d = 1'b1;
      end
    end
    res_d.feedback_on = fb_d;

    sum_d       = sum_q + in_byte_i;
    count_d     = total;
    out_valid_d = done | (out_valid_q & ~out_ready_i);
  end

  // Frame state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      head_q      <= '0;
      cmd_q       <= '0;
      len_q       <= '0;
      data1_q     <= '0;
      fb_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (done) begin
        count_q <= '0;
        sum_q   <= '0;
        head_q  <= '0;
        cmd_q   <= '0;
        len_q   <= '0;
        data1_q <= '0;
        fb_q    <= fb_d;
      end else if (in_adv_o) begin
        count_q <= count_d;
        sum_q   <= sum_d;
        head_q  <= head_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        data1_q <= data1_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // A DAC write only comes from an accepted set-parameter frame
  a_dac_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.dac_write |->
      res_q.charge_enable && res_q.set_param_seen && res_q.status == sfrc_pkg::ST_OK)
    else $error("dac_write without accepted set-parameter frame");

  // Level is zero when no DAC write is requested
  a_dac_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.dac_write |-> res_q.dac_level == '0)
    else $error("dac_level nonzero without dac_write");

  // Nothing clears the feedback flag
  a_fb_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_q)
    else $error("feedback flag cleared");

  // Closing a frame clears the byte count and sum and raises the result valid
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> count_q == '0 && sum_q == '0 && out_valid_q)
    else $error("frame state not cleared after last byte");

  // A waiting result is not replaced by a new frame end
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !done)
    else $error("pending result overwritten");

endmodule

// ===== bench/sum8_frame_receive_checker_core_test.sv =====
// Testbench for sum8_frame_receive_checker_core: frame stimulus, result scoreboard.
// Depends on sfrc_pkg and the RTL under rtl/; self-contained otherwise.

module sum8_frame_receive_checker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxBytes   = sfrc_pkg::MaxFrameBytesDef;
  localparam int unsigned DrainLimit = 100000;
  localparam int unsigned SettleCyc  = 6;      // margin past the input and result registers
  localparam int unsigned RandBytes  = 1100;
  localparam int unsigned NumPhases  = 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // DUT connections
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;     // [7:0] rx_byte
  logic             s_axis_tlast  = 1'b0;   // frame_end
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;           // [2:0] status, [3] set_param_seen,
                                            // [4] charge_enable, [5] dac_write,
                                            // [17:6] dac_level, [18] feedback_on
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [sfrc_pkg::AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata        = '0;
  logic [31:0]      prdata;
  logic             pready;

  // Shadow configuration and frame state of the predictor
  sfrc_pkg::cfg_t shadow_cfg = '{sfrc_pkg::HeadValueRst, sfrc_pkg::SetParamCodeRst,
                                 sfrc_pkg::DacCodeLowRst, sfrc_pkg::DacCodeHighRst};
  logic [8:0]  rx_count   = '0;
  logic [7:0]  rx_sum     = '0;
  logic [7:0]  rx_head    = '0;
  logic [7:0]  rx_cmd     = '0;
  logic [7:0]  rx_len     = '0;
  logic [7:0]  rx_data0   = '0;
  logic        fb_flag    = 1'b1;

  sfrc_pkg::result_t pending_results[$];
  logic [7:0]  frame_buf[$];

  int unsigned sender_idle_pct = 0;
  int unsigned rcv_stall_pct   = 0;
  int unsigned mismatch_count  = 0;
  int unsigned bytes_sent      = 0;
  int unsigned frames_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 1;
  int unsigned status_hist[5]  = '{default: 0};

  sum8_frame_receive_checker_core #(
    .MAX_FRAME_BYTES(MaxBytes)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // Frame checker prediction: absorbs one byte, returns 1 when a result is due
  function automatic bit absorb_rx_byte(input logic [7:0] b, input logic is_last,
                                        output sfrc_pkg::result_t res);
    int unsigned pos;
    int unsigned total;
    pos = rx_count;
    res = '0;
    if (pos == 0) rx_head = b;
    else if (pos == 3) rx_cmd = b;
    else if (pos == 4) rx_len = b;
    else if (pos == 5) rx_data0 = b;
    total = (pos < MaxBytes) ? pos + 1 : MaxBytes;
    if (!is_last) begin
      rx_count = 9'(total);
      rx_sum   = rx_sum + b;
      return 1'b0;
    end
    // checks go in fixed priority order
    if (total < sfrc_pkg::MinFrameBytes) res.status = sfrc_pkg::ST_TOO_SHORT;
    else if (rx_head != shadow_cfg.head_value) res.status = sfrc_pkg::ST_BAD_HEAD;
    else if (total != sfrc_pkg::OverheadBytes + rx_len) res.status = sfrc_pkg::ST_BAD_LEN;
    else if (b != rx_sum) res.status = sfrc_pkg::ST_BAD_SUM;
    else res.status = sfrc_pkg::ST_OK;
    if (res.status == sfrc_pkg::ST_OK && rx_cmd == shadow_cfg.set_param_code) begin
      res.set_param_seen = 1'b1;
      if (rx_data0 == sfrc_pkg::ParamLow) begin
        res.charge_enable = 1'b1;
        res.dac_write     = 1'b1;
        res.dac_level     = shadow_cfg.dac_code_low;
      end else if (rx_data0 == sfrc_pkg::ParamHigh) begin
        res.charge_enable = 1'b1;
        res.dac_write     = 1'b1;
        res.dac_level     = shadow_cfg.dac_code_high;
      end else if (rx_data0 == sfrc_pkg::ParamFeedback) begin
        fb_flag = 1'b1;
      end
    end
    res.feedback_on = fb_flag;
    rx_count = '0;
    rx_sum   = '0;
    rx_head  = '0;
    rx_cmd   = '0;
    rx_len   = '0;
    rx_data0 = '0;
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    sfrc_pkg::result_t got;
    sfrc_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = sfrc_pkg::result_t'(m_axis_tdata[18:0]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual 0x%06h", $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        compare_field("status", want.status, got.status);
        compare_field("set_param_seen", want.set_param_seen, got.set_param_seen);
        compare_field("charge_enable", want.charge_enable, got.charge_enable);
        compare_field("dac_write", want.dac_write, got.dac_write);
        compare_field("dac_level", want.dac_level, got.dac_level);
        compare_field("feedback_on", want.feedback_on, got.feedback_on);
        compare_field("tdata padding", 0, m_axis_tdata[23:19]);
        if (int'(got.status) < 5) status_hist[int'(got.status)]++;
      end
    end
  end

  task automatic set_idle_mode(input idle_mode_e mode);
    sender_idle_pct = 0;
    rcv_stall_pct   = 0;
    case (mode)
      IDLE_SENDER: begin
        sender_idle_pct = 78;
      end
      IDLE_RECEIVER: begin
        rcv_stall_pct = 78;
      end
      IDLE_BOTH: begin
        sender_idle_pct = 6;
        rcv_stall_pct   = 6;
      end
      default: ;
    endcase
  endtask

  // Sends one byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] data, input logic is_last);
    sfrc_pkg::result_t res;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = data;
    s_axis_tlast  = is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (absorb_rx_byte(data, is_last, res)) pending_results.push_back(res);
    bytes_sent++;
    if (is_last) frames_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame_buf();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Well-formed frame with a correct checksum; len_field may disagree with n_data
  task automatic build_frame(input logic [7:0] head, input logic [7:0] cmd,
                             input logic [7:0] len_field, input int n_data,
                             input logic [7:0] first_data);
    logic [7:0] csum;
    frame_buf.delete();
    frame_buf.push_back(head);
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(cmd);
    frame_buf.push_back(len_field);
    for (int i = 0; i < n_data; i++) frame_buf.push_back(i == 0 ? first_data : 8'($urandom));
    csum = '0;
    foreach (frame_buf[i]) csum = csum + frame_buf[i];
    frame_buf.push_back(csum);
  endtask

  // Waits until every expected result has arrived and the pipeline is empty
  task automatic wait_drained();
    int unsigned n;
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    n = 0;
    while (pending_results.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCyc) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input sfrc_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      sfrc_pkg::REG_HEAD_VALUE:     shadow_cfg.head_value     = value[7:0];
      sfrc_pkg::REG_SET_PARAM_CODE: shadow_cfg.set_param_code = value[7:0];
      sfrc_pkg::REG_DAC_CODE_LOW:   shadow_cfg.dac_code_low   = value[11:0];
      sfrc_pkg::REG_DAC_CODE_HIGH:  shadow_cfg.dac_code_high  = value[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic verify_reg(input sfrc_pkg::reg_idx_e idx, input logic [31:0] want);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    compare_field($sformatf("readback of %s", idx.name()), want, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Writes all four registers once the block is idle, then reads them back
  task automatic apply_config(input logic [7:0] head, input logic [7:0] code,
                              input logic [11:0] lo, input logic [11:0] hi);
    wait_drained();
    // upper bits of the first three writes set on purpose: the block keeps only the register width
    write_reg(sfrc_pkg::REG_HEAD_VALUE, {24'hA5A5A5, head});
    write_reg(sfrc_pkg::REG_SET_PARAM_CODE, {24'h5A5A5A, code});
    write_reg(sfrc_pkg::REG_DAC_CODE_LOW, {20'hFFFFF, lo});
    write_reg(sfrc_pkg::REG_DAC_CODE_HIGH, {20'h00000, hi});
    verify_reg(sfrc_pkg::REG_HEAD_VALUE, shadow_cfg.head_value);
    verify_reg(sfrc_pkg::REG_SET_PARAM_CODE, shadow_cfg.set_param_code);
    verify_reg(sfrc_pkg::REG_DAC_CODE_LOW, shadow_cfg.dac_code_low);
    verify_reg(sfrc_pkg::REG_DAC_CODE_HIGH, shadow_cfg.dac_code_high);
    settings_used++;
  endtask

  // Reset values, then extremes, then back to reset values
  task automatic test_register_access();
    set_idle_mode(IDLE_NONE);
    verify_reg(sfrc_pkg::REG_HEAD_VALUE, sfrc_pkg::HeadValueRst);
    verify_reg(sfrc_pkg::REG_SET_PARAM_CODE, sfrc_pkg::SetParamCodeRst);
    verify_reg(sfrc_pkg::REG_DAC_CODE_LOW, sfrc_pkg::DacCodeLowRst);
    verify_reg(sfrc_pkg::REG_DAC_CODE_HIGH, sfrc_pkg::DacCodeHighRst);
    apply_config(8'hFF, 8'hFF, 12'hFFF, 12'hFFF);
    apply_config(8'h00, 8'h00, 12'h000, 12'h000);
    apply_config(sfrc_pkg::HeadValueRst, sfrc_pkg::SetParamCodeRst,
                 sfrc_pkg::DacCodeLowRst, sfrc_pkg::DacCodeHighRst);
  endtask

  // Accepted frames: each set-parameter value, other value, other command
  task automatic test_accepted_frames();
    set_idle_mode(IDLE_NONE);
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd1, 1,
                sfrc_pkg::ParamLow);
    send_frame_buf();
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd1, 1,
                sfrc_pkg::ParamHigh);
    send_frame_buf();
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd1, 1,
                sfrc_pkg::ParamFeedback);
    send_frame_buf();
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd1, 1, 8'hFF);
    send_frame_buf();
    build_frame(shadow_cfg.head_value, 8'hFF, 8'd1, 1, sfrc_pkg::ParamLow);
    send_frame_buf();
  endtask

  // Each rejection reason once, too short in two forms
  task automatic test_rejected_frames();
    set_idle_mode(IDLE_NONE);
    send_byte(8'h00, 1'b1);
    // six bytes with consistent header and checksum is still too short
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd0, 0, 8'h00);
    send_frame_buf();
    build_frame(~shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd1, 1,
                sfrc_pkg::ParamLow);
    send_frame_buf();
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd3, 1,
                sfrc_pkg::ParamLow);
    send_frame_buf();
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd1, 1,
                sfrc_pkg::ParamHigh);
    frame_buf[frame_buf.size() - 1] ^= 8'h80;
    send_frame_buf();
  endtask

  // Largest length field, and a frame running past the byte-count ceiling
  task automatic test_long_frames();
    set_idle_mode(IDLE_BOTH);
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd255, 255,
                sfrc_pkg::ParamHigh);
    send_frame_buf();
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd255, 513,
                sfrc_pkg::ParamLow);
    send_frame_buf();
    // short frame right after the saturated one: count must start over
    build_frame(shadow_cfg.head_value, shadow_cfg.set_param_code, 8'd1, 1,
                sfrc_pkg::ParamLow);
    send_frame_buf();
  endtask

  // One random frame: mostly well-formed, the rest broken or noise
  task automatic send_random_frame();
    int unsigned kind;
    int unsigned r;
    int          n_data;
    logic [7:0]  cmd;
    logic [7:0]  first_data;
    logic [7:0]  len_field;
    int unsigned keep;
    kind = $urandom_range(0, 99);
    r    = $urandom_range(0, 99);
    if (r < 70) n_data = $urandom_range(1, 8);
    else if (r < 99) n_data = $urandom_range(9, 40);
    else n_data = $urandom_range(41, 255);
    cmd = ($urandom_range(0, 99) < 65) ? shadow_cfg.set_param_code : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 30) first_data = sfrc_pkg::ParamLow;
    else if (r < 55) first_data = sfrc_pkg::ParamHigh;
    else if (r < 75) first_data = sfrc_pkg::ParamFeedback;
    else first_data = 8'($urandom);
    len_field = 8'(n_data);
    if (kind < 60) begin
      build_frame(shadow_cfg.head_value, cmd, len_field, n_data, first_data);
    end else if (kind < 67) begin
      build_frame(shadow_cfg.head_value ^ 8'($urandom_range(1, 255)), cmd, len_field,
                  n_data, first_data);
    end else if (kind < 74) begin
      len_field = 8'($urandom);
      if (len_field == 8'(n_data)) len_field = len_field + 8'd1;
      build_frame(shadow_cfg.head_value, cmd, len_field, n_data, first_data);
    end else if (kind < 83) begin
      build_frame(shadow_cfg.head_value, cmd, len_field, n_data, first_data);
      frame_buf[frame_buf.size() - 1] ^= 8'($urandom_range(1, 255));
    end else if (kind < 90) begin
      build_frame(shadow_cfg.head_value, cmd, len_field, n_data, first_data);
      keep = $urandom_range(1, 6);
      while (frame_buf.size() > keep) void'(frame_buf.pop_back());
    end else begin
      // noise: random bytes, random early frame ends
      frame_buf.delete();
      keep = $urandom_range(1, 12);
      for (int i = 0; i < keep; i++) begin
        send_byte(8'($urandom), (i == keep - 1) || ($urandom_range(0, 7) == 0));
      end
      return;
    end
    send_frame_buf();
  endtask

  // Random frames over several register settings and idle patterns
  task automatic test_random_traffic();
    int unsigned phase_end;
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: apply_config(sfrc_pkg::HeadValueRst, sfrc_pkg::SetParamCodeRst,
                        sfrc_pkg::DacCodeLowRst, sfrc_pkg::DacCodeHighRst);
        1: apply_config(8'h00, 8'h00, 12'h000, 12'hFFF);
        2: apply_config(8'hFF, 8'hFF, 12'hFFF, 12'h000);
        default: apply_config(8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
      endcase
      set_idle_mode(idle_mode_e'(p % 4));
      phase_end = bytes_sent + RandBytes / NumPhases;
      while (bytes_sent < phase_end) send_random_frame();
    end
  endtask

  // Main sequence
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_register_access();
    test_accepted_frames();
    test_rejected_frames();
    test_long_frames();
    test_random_traffic();
    wait_drained();
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Summary: %0d bytes in %0d frames, %0d results checked, %0d register settings",
             bytes_sent, frames_sent, results_checked, settings_used);
    $display("Statuses seen: ok %0d, too short %0d, bad head %0d, bad length %0d, bad sum %0d",
             status_hist[0], status_hist[1], status_hist[2], status_hist[3], status_hist[4]);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout at %0t", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
